// File: hw/rtl/hmt_pkg.sv
// ----------------------------------------------------------------------------
// hmt_pkg
// shared types, codes and defaults of the heartbeat membership table
// ----------------------------------------------------------------------------
package hmt_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam logic [15:0] RST_REMOVE_TIMEOUT = 16'd20;

    typedef enum logic [2:0] {
        ACT_JOIN_REQ  = 3'd0,
        ACT_JOIN_REP  = 3'd1,
        ACT_PING      = 3'd2,
        ACT_GOSSIP    = 3'd3,
        ACT_TICK      = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        EV_ADDED   = 3'd0,
        EV_REMOVED = 3'd1,
        EV_JOINREP = 3'd2,
        EV_PING    = 3'd3,
        EV_DONE    = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        CFG_OWN_ID        = 2'd0,
        CFG_OWN_PORT      = 2'd1,
        CFG_REMOVE_TMO    = 2'd2,
        CFG_IS_INTRODUCER = 2'd3
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_EV,
        S_ACT,
        S_EM_ADD,
        S_EM_JREP,
        S_CNT_RD,
        S_CNT_EV,
        S_RM_RD,
        S_RM_EV,
        S_PG_RD,
        S_PG_EV,
        S_EM_DONE
    } state_t;

    typedef struct packed {
        logic   ld_in;
        logic   idx_clr;
        logic   idx_inc;
        logic   idx_dec;
        logic   rd_en;
        logic   rd_desc;
        logic   found_set;
        logic   ins;
        logic   upd_ping;
        logic   upd_gossip;
        logic   set_joined;
        logic   beat_inc;
        logic   keep_clr;
        logic   keep_inc;
        logic   commit;
        logic   wr_clr;
        logic   compact_wr;
        logic   emit;
        event_t emit_ev;
    } cmd_t;

    typedef struct packed {
        action_t action;
        logic    idx_at_cnt;
        logic    idx_at_lim;
        logic    idx_zero;
        logic    match;
        logic    found;
        logic    full;
        logic    stale;
        logic    hb_greater;
        logic    gossip_ok;
        logic    joined;
        logic    out_free;
    } status_t;

endpackage

// File: hw/rtl/heartbeat_membership_table.sv
// ----------------------------------------------------------------------------
// heartbeat_membership_table
// bounded gossip membership table with heartbeat failure detection
//
//  channel  dir  handshake           payload
//  s_axis   in   tvalid / tready     tuser action, tdata peer fields
//  m_axis   out  tvalid / tready     tuser event, tlast, tdata result fields
//  cfg      in   cfg_we              cfg_index, cfg_data
//
//  a search reads and then compares one member at a time until the match or
//  the table end, on a member memory with one read port, one write port and
//  registered read; an update or insert follows; a tick of a joined node sweeps
//  the table three times, reading and then checking each member (count,
//  removal, ping and compaction); removals and pings leave from inside the
//  sweep, every other result has a state of its own
//  reset clears the table count, own heartbeat and joined flag at once
//  a stalled result holds the sweep; the next request is taken once done sits in the result register
// ----------------------------------------------------------------------------
module heartbeat_membership_table
    import hmt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [119:0] s_axis_tdata,  // peer_id, peer_port, peer_heartbeat, peer_stamp, now_time
    input  logic [2:0]   s_axis_tuser,  // action
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // target_id, target_port, self_heartbeat, group_joined,
                                        // member_count, zero fill
    output logic [2:0]   m_axis_tuser,  // event_res
    output logic         m_axis_tlast
);

    cmd_t        cmd;
    status_t     st;
    logic        in_ready;
    logic [7:0]  res_id;
    logic [15:0] res_port;
    logic [31:0] res_beat;
    logic        res_joined;
    logic [4:0]  res_count;

    assign s_axis_tready = in_ready;

    hmt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && in_ready),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    hmt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_action         (s_axis_tuser),
        .in_peer_id        (s_axis_tdata[7:0]),
        .in_peer_port      (s_axis_tdata[23:8]),
        .in_peer_heartbeat (s_axis_tdata[55:24]),
        .in_peer_stamp     (s_axis_tdata[87:56]),
        .in_now_time       (s_axis_tdata[119:88]),
        .cmd               (cmd),
        .st                (st),
        .out_ready         (m_axis_tready),
        .out_valid         (m_axis_tvalid),
        .out_event         (m_axis_tuser),
        .out_id            (res_id),
        .out_port          (res_port),
        .out_beat          (res_beat),
        .out_joined        (res_joined),
        .out_count         (res_count),
        .out_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, res_count, res_joined, res_beat, res_port, res_id};

endmodule

// File: hw/rtl/hmt_ctrl.sv
// ----------------------------------------------------------------------------
// hmt_ctrl
// sequencer for table search, update, tick sweeps and result emission
// ----------------------------------------------------------------------------
module hmt_ctrl
    import hmt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_fire,
    output logic    in_ready,
    input  status_t st,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_FIND_RD;
                end
            end
            S_FIND_RD:
            begin
                if (st.action == ACT_TICK || st.idx_at_cnt)
                begin
                    state_next = S_ACT;
                end
                else
                begin
                    state_next = S_FIND_EV;
                end
            end
            S_FIND_EV:
            begin
                state_next = st.match ? S_ACT : S_FIND_RD;
            end
            S_ACT:
            begin
                state_next = S_EM_DONE;
                case (st.action)
                    ACT_JOIN_REQ:
                    begin
                        state_next = (!st.found && !st.full) ? S_EM_ADD : S_EM_JREP;
                    end
                    ACT_JOIN_REP:
                    begin
                        if (!st.found && !st.full)
                        begin
                            state_next = S_EM_ADD;
                        end
                    end
                    ACT_PING:
                    begin
                        if (!st.found && !st.full)
                        begin
                            state_next = S_EM_ADD;
                        end
                    end
                    ACT_GOSSIP:
                    begin
                        if (!st.found && !st.full && st.gossip_ok)
                        begin
                            state_next = S_EM_ADD;
                        end
                    end
                    ACT_TICK:
                    begin
                        if (st.joined)
                        begin
                            state_next = S_CNT_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_EM_DONE;
                    end
                endcase
            end
            S_EM_ADD:
            begin
                if (st.out_free)
                begin
                    state_next = (st.action == ACT_JOIN_REQ) ? S_EM_JREP : S_EM_DONE;
                end
            end
            S_EM_JREP:
            begin
                if (st.out_free)
                begin
                    state_next = S_EM_DONE;
                end
            end
            S_CNT_RD:
            begin
                state_next = st.idx_at_cnt ? S_RM_RD : S_CNT_EV;
            end
            S_CNT_EV:
            begin
                state_next = S_CNT_RD;
            end
            S_RM_RD:
            begin
                state_next = st.idx_zero ? S_PG_RD : S_RM_EV;
            end
            S_RM_EV:
            begin
                if (!st.stale || st.out_free)
                begin
                    state_next = S_RM_RD;
                end
            end
            S_PG_RD:
            begin
                state_next = st.idx_at_lim ? S_EM_DONE : S_PG_EV;
            end
            S_PG_EV:
            begin
                if (st.stale || st.out_free)
                begin
                    state_next = S_PG_RD;
                end
            end
            S_EM_DONE:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.emit_ev = EV_DONE;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.ld_in   = in_fire;
                cmd.idx_clr = in_fire;
            end
            S_FIND_RD:
            begin
                cmd.rd_en = (st.action != ACT_TICK) && !st.idx_at_cnt;
            end
            S_FIND_EV:
            begin
                cmd.found_set = st.match;
                cmd.idx_inc   = !st.match;
            end
            S_ACT:
            begin
                case (st.action)
                    ACT_JOIN_REQ:
                    begin
                        cmd.ins = !st.found && !st.full;
                    end
                    ACT_JOIN_REP:
                    begin
                        cmd.ins        = !st.found && !st.full;
                        cmd.set_joined = 1'b1;
                    end
                    ACT_PING:
                    begin
                        cmd.ins      = !st.found && !st.full;
                        cmd.upd_ping = st.found;
                    end
                    ACT_GOSSIP:
                    begin
                        cmd.ins        = !st.found && !st.full && st.gossip_ok;
                        cmd.upd_gossip = st.found && st.hb_greater;
                    end
                    ACT_TICK:
                    begin
                        cmd.beat_inc = st.joined;
                        cmd.keep_clr = st.joined;
                        cmd.idx_clr  = st.joined;
                    end
                    default:
                    begin
                        cmd.ins = 1'b0;
                    end
                endcase
            end
            S_EM_ADD:
            begin
                cmd.emit    = st.out_free;
                cmd.emit_ev = EV_ADDED;
            end
            S_EM_JREP:
            begin
                cmd.emit    = st.out_free;
                cmd.emit_ev = EV_JOINREP;
            end
            S_CNT_RD:
            begin
                cmd.rd_en  = !st.idx_at_cnt;
                cmd.commit = st.idx_at_cnt;
            end
            S_CNT_EV:
            begin
                cmd.keep_inc = !st.stale;
                cmd.idx_inc  = 1'b1;
            end
            S_RM_RD:
            begin
                cmd.rd_en   = !st.idx_zero;
                cmd.rd_desc = 1'b1;
                cmd.idx_clr = st.idx_zero;
                cmd.wr_clr  = st.idx_zero;
            end
            S_RM_EV:
            begin
                cmd.emit    = st.stale && st.out_free;
                cmd.emit_ev = EV_REMOVED;
                cmd.idx_dec = !st.stale || st.out_free;
            end
            S_PG_RD:
            begin
                cmd.rd_en = !st.idx_at_lim;
            end
            S_PG_EV:
            begin
                cmd.emit       = !st.stale && st.out_free;
                cmd.emit_ev    = EV_PING;
                cmd.compact_wr = !st.stale && st.out_free;
                cmd.idx_inc    = st.stale || st.out_free;
            end
            S_EM_DONE:
            begin
                cmd.emit    = st.out_free;
                cmd.emit_ev = EV_DONE;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: hw/rtl/hmt_dp.sv
// ----------------------------------------------------------------------------
// hmt_dp
// member memory, counters, configuration and result register
// ----------------------------------------------------------------------------
module hmt_dp
    import hmt_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [2:0]  in_action,
    input  logic [7:0]  in_peer_id,
    input  logic [15:0] in_peer_port,
    input  logic [31:0] in_peer_heartbeat,
    input  logic [31:0] in_peer_stamp,
    input  logic [31:0] in_now_time,
    input  cmd_t        cmd,
    output status_t     st,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [2:0]  out_event,
    output logic [7:0]  out_id,
    output logic [15:0] out_port,
    output logic [31:0] out_beat,
    output logic        out_joined,
    output logic [4:0]  out_count,
    output logic        out_last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] port;
        logic [31:0] hb;
        logic [31:0] tm;
    } entry_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_q;

    logic [7:0]  own_id_reg;
    logic [15:0] own_port_reg;
    logic [15:0] tmo_reg;
    logic        intro_reg;

    action_t     act_reg;
    logic [7:0]  id_reg;
    logic [15:0] port_reg;
    logic [31:0] hb_reg;
    logic [31:0] stamp_reg;
    logic [31:0] now_reg;

    logic [CW-1:0] idx_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] lim_reg;
    logic [CW-1:0] keep_reg;
    logic [CW-1:0] wr_reg;
    logic [AW-1:0] pos_reg;
    logic          found_reg;
    logic [31:0]   beat_reg;
    logic          joined_reg;

    logic          valid_reg;
    logic [2:0]    ev_reg;
    logic [7:0]    oid_reg;
    logic [15:0]   oport_reg;
    logic [31:0]   obeat_reg;
    logic          ojoined_reg;
    logic [4:0]    ocount_reg;
    logic          olast_reg;

    logic [CW-1:0] idx_m1;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic [31:0]   stale_age;
    logic [31:0]   stamp_age;
    logic          out_free;

    assign idx_m1   = idx_reg - CW'(1);
    assign rd_addr  = cmd.rd_desc ? idx_m1[AW-1:0] : idx_reg[AW-1:0];
    assign out_free = !valid_reg || out_ready;

    assign stale_age = (rd_q.tm > now_reg) ? 32'd0 : now_reg - rd_q.tm;
    assign stamp_age = (stamp_reg > now_reg) ? 32'd0 : now_reg - stamp_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[AW-1:0];
        wr_data = rd_q;
        if (cmd.ins)
        begin
            wr_en        = 1'b1;
            wr_addr      = cnt_reg[AW-1:0];
            wr_data.id   = id_reg;
            wr_data.port = port_reg;
            wr_data.hb   = (act_reg == ACT_GOSSIP) ? hb_reg : 32'd1;
            wr_data.tm   = (act_reg == ACT_GOSSIP) ? stamp_reg : now_reg;
        end
        else if (cmd.upd_ping || cmd.upd_gossip)
        begin
            wr_en      = 1'b1;
            wr_addr    = pos_reg;
            wr_data.hb = cmd.upd_ping ? rd_q.hb + 32'd1 : hb_reg;
            wr_data.tm = now_reg;
        end
        else if (cmd.compact_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = wr_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            act_reg   <= action_t'(in_action);
            id_reg    <= in_peer_id;
            port_reg  <= in_peer_port;
            hb_reg    <= in_peer_heartbeat;
            stamp_reg <= in_peer_stamp;
            now_reg   <= in_now_time;
        end
        if (cmd.found_set)
        begin
            pos_reg <= idx_reg[AW-1:0];
        end
        if (cmd.emit)
        begin
            ev_reg      <= cmd.emit_ev;
            olast_reg   <= (cmd.emit_ev == EV_DONE);
            obeat_reg   <= beat_reg;
            ojoined_reg <= joined_reg || intro_reg;
            ocount_reg  <= 5'(cnt_reg);
            case (cmd.emit_ev) inside
                EV_ADDED, EV_JOINREP:
                begin
                    oid_reg   <= id_reg;
                    oport_reg <= port_reg;
                end
                EV_REMOVED, EV_PING:
                begin
                    oid_reg   <= rd_q.id;
                    oport_reg <= rd_q.port;
                end
                default:
                begin
                    oid_reg   <= 8'd0;
                    oport_reg <= 16'd0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_id_reg   <= 8'd0;
            own_port_reg <= 16'd0;
            tmo_reg      <= RST_REMOVE_TIMEOUT;
            intro_reg    <= 1'b0;
            idx_reg      <= '0;
            cnt_reg      <= '0;
            lim_reg      <= '0;
            keep_reg     <= '0;
            wr_reg       <= '0;
            found_reg    <= 1'b0;
            beat_reg     <= 32'd0;
            joined_reg   <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_OWN_ID:        own_id_reg   <= cfg_data[7:0];
                    CFG_OWN_PORT:      own_port_reg <= cfg_data;
                    CFG_REMOVE_TMO:    tmo_reg      <= cfg_data;
                    CFG_IS_INTRODUCER: intro_reg    <= cfg_data[0];
                    default:           intro_reg    <= intro_reg;
                endcase
            end
            if (cmd.ld_in)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.found_set)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                idx_reg <= cnt_reg;
                lim_reg <= cnt_reg;
                cnt_reg <= keep_reg;
            end
            else
            begin
                if (cmd.idx_clr)
                begin
                    idx_reg <= '0;
                end
                else if (cmd.idx_inc)
                begin
                    idx_reg <= idx_reg + CW'(1);
                end
                else if (cmd.idx_dec)
                begin
                    idx_reg <= idx_m1;
                end
                if (cmd.ins)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            if (cmd.keep_clr)
            begin
                keep_reg <= '0;
            end
            else if (cmd.keep_inc)
            begin
                keep_reg <= keep_reg + CW'(1);
            end
            if (cmd.wr_clr)
            begin
                wr_reg <= '0;
            end
            else if (cmd.compact_wr)
            begin
                wr_reg <= wr_reg + CW'(1);
            end
            if (cmd.beat_inc)
            begin
                beat_reg <= beat_reg + 32'd1;
            end
            if (cmd.set_joined)
            begin
                joined_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        st.action     = act_reg;
        st.idx_at_cnt = (idx_reg == cnt_reg);
        st.idx_at_lim = (idx_reg == lim_reg);
        st.idx_zero   = (idx_reg == '0);
        st.match      = (rd_q.id == id_reg) && (rd_q.port == port_reg);
        st.found      = found_reg;
        st.full       = (cnt_reg == CW'(TABLE_DEPTH));
        st.stale      = (stale_age >= {16'd0, tmo_reg});
        st.hb_greater = (hb_reg > rd_q.hb);
        st.gossip_ok  = !((id_reg == own_id_reg) && (port_reg == own_port_reg)) &&
                        (stamp_age < {16'd0, tmo_reg});
        st.joined     = joined_reg || intro_reg;
        st.out_free   = out_free;
    end

    assign out_valid  = valid_reg;
    assign out_event  = ev_reg;
    assign out_id     = oid_reg;
    assign out_port   = oport_reg;
    assign out_beat   = obeat_reg;
    assign out_joined = ojoined_reg;
    assign out_count  = ocount_reg;
    assign out_last   = olast_reg;

endmodule
